// ===== design/sarsu_pkg.sv =====
// shared types and constants for the summed-area table region sum unit
// no dependencies; imported by sarsu_cfg, the top level and the testbench
package sarsu_pkg;

  localparam int CFG_DIM_BITS  = 7;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int STATUS_BITS   = 2;

  localparam logic [CFG_DIM_BITS-1:0] CFG_DIM_RESET = 7'd64;

  // register index, taken from paddr bit 2
  localparam logic REG_NUM_ROWS = 1'b0;
  localparam logic REG_NUM_COLS = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic [STATUS_BITS-1:0] status_t;

  localparam status_t STATUS_OK        = 2'd0;
  localparam status_t STATUS_BAD_COORD = 2'd1;
  localparam status_t STATUS_NOT_READY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD_WR,
    ST_QUERY,
    ST_FINISH
  } state_t;

endpackage

// ===== design/sarsu_cfg.sv =====
// apb-style register block for the matrix dimensions, with clamping to the table size
// depends on sarsu_pkg
module sarsu_cfg import sarsu_pkg::*; #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64,
  localparam int RDW = $clog2(MAX_ROWS + 1),
  localparam int CDW = $clog2(MAX_COLS + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output logic [RDW-1:0]           rows,
  output logic [CDW-1:0]           cols,
  output logic                     restart
);

  localparam int RCMP = (RDW > CFG_DIM_BITS) ? RDW : CFG_DIM_BITS;
  localparam int CCMP = (CDW > CFG_DIM_BITS) ? CDW : CFG_DIM_BITS;

  logic [CFG_DIM_BITS-1:0] num_rows;
  logic [CFG_DIM_BITS-1:0] num_cols;
  logic                    wr;

  assign pready  = 1'b1;
  assign wr      = psel & penable & pwrite;
  assign restart = wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_rows <= CFG_DIM_RESET;
      num_cols <= CFG_DIM_RESET;
    end else if (wr) begin
      case (paddr[2])
        REG_NUM_ROWS: num_rows <= pwdata[CFG_DIM_BITS-1:0];
        REG_NUM_COLS: num_cols <= pwdata[CFG_DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_NUM_ROWS: prdata = CFG_DATA_BITS'(num_rows);
      REG_NUM_COLS: prdata = CFG_DATA_BITS'(num_cols);
      default:      prdata = '0;
    endcase
  end

  // zero acts as one, anything above the table size saturates
  always_comb begin
    if (num_rows == '0) begin
      rows = RDW'(1);
    end else if (RCMP'(num_rows) > RCMP'(MAX_ROWS)) begin
      rows = RDW'(MAX_ROWS);
    end else begin
      rows = RDW'(num_rows);
    end
    if (num_cols == '0) begin
      cols = CDW'(1);
    end else if (CCMP'(num_cols) > CCMP'(MAX_COLS)) begin
      cols = CDW'(MAX_COLS);
    end else begin
      cols = CDW'(num_cols);
    end
  end

endmodule

// ===== design/summed_area_table_region_sum_unit.sv =====
// Summed-area table region sum unit. Elements load one per item in raster order; each
// load reads the table entry above through the single read port and writes the new
// prefix entry in the next cycle. A query reads its four corners one after the other
// through the same port; a query with bad coordinates or an incomplete table skips the
// reads. A new item is accepted only in the idle state, once the last one is done.
// Results sit in an output register, so loads continue while a result waits; a query
// that finishes while the previous result is still waiting holds until it is taken.
// The table memory holds MAX_ROWS*MAX_COLS entries and needs no clearing after reset.
module summed_area_table_region_sum_unit import sarsu_pkg::*; #(
  parameter int MAX_ROWS  = 64,
  parameter int MAX_COLS  = 64,
  parameter int ELEM_BITS = 16,
  localparam int RB       = $clog2(MAX_ROWS),
  localparam int CB       = $clog2(MAX_COLS),
  localparam int SUM_BITS = ELEM_BITS + RB + CB
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        command,
  input  logic signed [ELEM_BITS-1:0] value,
  input  logic [RB-1:0]               top_row,
  input  logic [CB-1:0]               left_col,
  input  logic [RB-1:0]               bottom_row,
  input  logic [CB-1:0]               right_col,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [SUM_BITS-1:0]  region_sum,
  output status_t                     status,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [CFG_ADDR_BITS-1:0]    paddr,
  input  logic [CFG_DATA_BITS-1:0]    pwdata,
  output logic [CFG_DATA_BITS-1:0]    prdata,
  output logic                        pready
);

  localparam int RDW   = $clog2(MAX_ROWS + 1);
  localparam int CDW   = $clog2(MAX_COLS + 1);
  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RSW   = ELEM_BITS + CB;

  logic [RDW-1:0] rows;
  logic [CDW-1:0] cols;
  logic           cfg_write;

  sarsu_cfg #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .rows    (rows),
    .cols    (cols),
    .restart (cfg_write)
  );

  function automatic logic [AW-1:0] addr_of(input logic [RB-1:0] r, input logic [CB-1:0] c);
    return AW'(r) * AW'(MAX_COLS) + AW'(c);
  endfunction

  state_t state;
  state_t state_next;

  logic [RB-1:0]              load_row;
  logic [CB-1:0]              load_col;
  logic signed [RSW-1:0]      row_sum;
  logic signed [RSW-1:0]      row_sum_next;
  logic                       table_complete;
  logic signed [ELEM_BITS-1:0] val_q;

  logic [RB-1:0] qt;
  logic [CB-1:0] ql;
  logic [RB-1:0] qb;
  logic [CB-1:0] qr;
  status_t       q_status;
  logic [2:0]    step;
  logic signed [SUM_BITS-1:0] acc;

  logic signed [SUM_BITS-1:0] mem [DEPTH];
  logic signed [SUM_BITS-1:0] mem_q;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic signed [SUM_BITS-1:0] wr_data;
  logic                       mem_we;
  logic                       out_load;

  logic                       accept;
  logic                       bad_coord;
  status_t                    status_in;
  logic                       last_col;
  logic                       last_row;
  logic [1:0]                 corner;
  logic                       corner_zero;
  logic                       corner_neg;
  logic signed [SUM_BITS-1:0] term;

  assign accept = in_valid & in_ready;

  always_comb begin
    bad_coord = (top_row > bottom_row) || (left_col > right_col) ||
                (RDW'(bottom_row) >= rows) || (CDW'(right_col) >= cols);
    if (bad_coord) begin
      status_in = STATUS_BAD_COORD;
    end else if (!table_complete) begin
      status_in = STATUS_NOT_READY;
    end else begin
      status_in = STATUS_OK;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command == CMD_LOAD) begin
            state_next = ST_LOAD_WR;
          end else if (status_in == STATUS_OK) begin
            state_next = ST_QUERY;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_LOAD_WR: state_next = ST_IDLE;
      ST_QUERY: begin
        if (step == 3'd4) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    mem_we   = 1'b0;
    out_load = 1'b0;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_LOAD_WR: mem_we = 1'b1;
      ST_QUERY:   ;
      ST_FINISH:  out_load = !out_valid || out_ready;
      default:    ;
    endcase
  end

  // read address: the query corner while querying, else the entry above the load position
  always_comb begin
    if (state == ST_QUERY) begin
      rd_addr = addr_of(step[0] ? qt - RB'(1) : qb, step[1] ? ql - CB'(1) : qr);
    end else begin
      rd_addr = addr_of(load_row - RB'(1), load_col);
    end
  end

  assign last_col = (CDW'(load_col) + CDW'(1)) >= cols;
  assign last_row = (RDW'(load_row) + RDW'(1)) >= rows;

  always_comb begin
    if (load_col == '0) begin
      row_sum_next = RSW'(val_q);
    end else begin
      row_sum_next = row_sum + RSW'(val_q);
    end
    wr_addr = addr_of(load_row, load_col);
    wr_data = SUM_BITS'(row_sum_next) + ((load_row == '0) ? '0 : mem_q);
  end

  // corner whose data arrives this cycle; the row or column before the first is zero
  always_comb begin
    corner      = 2'(step - 3'd1);
    corner_zero = (corner[0] && (qt == '0)) || (corner[1] && (ql == '0));
    corner_neg  = corner[0] ^ corner[1];
    term        = corner_zero ? '0 : mem_q;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= wr_data;
    mem_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      load_row       <= '0;
      load_col       <= '0;
      row_sum        <= '0;
      table_complete <= 1'b0;
      step           <= '0;
      out_valid      <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        val_q    <= value;
        qt       <= top_row;
        ql       <= left_col;
        qb       <= bottom_row;
        qr       <= right_col;
        q_status <= status_in;
        step     <= '0;
        acc      <= '0;
      end
      if (mem_we) begin
        row_sum <= row_sum_next;
        if (!last_col) begin
          load_col       <= load_col + CB'(1);
          table_complete <= 1'b0;
        end else if (!last_row) begin
          load_col       <= '0;
          load_row       <= load_row + RB'(1);
          table_complete <= 1'b0;
        end else begin
          load_col       <= '0;
          load_row       <= '0;
          table_complete <= 1'b1;
        end
      end
      if (state == ST_QUERY) begin
        step <= step + 3'd1;
        if (step != '0) begin
          acc <= corner_neg ? acc - term : acc + term;
        end
      end
      if (out_load) begin
        out_valid  <= 1'b1;
        region_sum <= (q_status == STATUS_OK) ? acc : '0;
        status     <= q_status;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        load_row       <= '0;
        load_col       <= '0;
        row_sum        <= '0;
        table_complete <= 1'b0;
      end
    end
  end

  // a new result only ever comes out of the finish state
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_FINISH)
    else $error("result appeared outside the finish state");

  // an ok result was computed against a complete table
  a_ok_needs_complete: assert property (@(posedge clk) disable iff (rst)
    (out_load && q_status == STATUS_OK) |-> table_complete)
    else $error("ok result delivered with incomplete table");

  // the corner sequencer never runs past its four reads
  a_step_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_QUERY) |-> (step <= 3'd4))
    else $error("query step counter overran");

  // table writes happen only in the load write state and never alongside a query
  a_write_only_load: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_LOAD_WR) && !in_ready && !out_load)
    else $error("table written outside a load");

endmodule

// ===== sim/sarsu_tb_pkg.sv =====
`timescale 1ns / 1ps
// prefix table predictor and result checker for the region sum unit testbench
// depends on sarsu_pkg for command, register and status codes
package sarsu_tb_pkg;
  import sarsu_pkg::*;

  localparam int DIM_MAX = 64;
  localparam int ELEM_W  = 16;
  localparam int COORD_W = 6;
  localparam int AREA_W  = 28;

  typedef struct packed {
    logic signed [AREA_W-1:0] area_sum;
    status_t                  status;
  } region_result_t;

  class region_sum_scoreboard;
    int             prefix [DIM_MAX*DIM_MAX];
    int             load_row;
    int             load_col;
    int             row_acc;
    bit             table_done;
    int             rows_used;
    int             cols_used;
    region_result_t awaited [$];
    int             errors;

    function new();
      foreach (prefix[i]) prefix[i] = 0;
      rows_used = DIM_MAX;
      cols_used = DIM_MAX;
      errors    = 0;
      restart_load();
    endfunction

    function void restart_load();
      load_row   = 0;
      load_col   = 0;
      row_acc    = 0;
      table_done = 1'b0;
    endfunction

    // zero acts as one, anything past the table size saturates
    static function int clamp_dim(logic [CFG_DIM_BITS-1:0] raw);
      if (raw == '0) return 1;
      if (int'(raw) > DIM_MAX) return DIM_MAX;
      return int'(raw);
    endfunction

    // negative coordinates stand for the zero border
    function int prefix_at(int r, int c);
      if (r < 0 || c < 0) return 0;
      return prefix[r*DIM_MAX + c];
    endfunction

    function void write_reg(logic idx, logic [CFG_DATA_BITS-1:0] data);
      if (idx == REG_NUM_ROWS) rows_used = clamp_dim(data[CFG_DIM_BITS-1:0]);
      else cols_used = clamp_dim(data[CFG_DIM_BITS-1:0]);
      restart_load();
    endfunction

    function void note_item(logic cmd, logic signed [ELEM_W-1:0] value,
                            logic [COORD_W-1:0] t, logic [COORD_W-1:0] l,
                            logic [COORD_W-1:0] b, logic [COORD_W-1:0] r);
      region_result_t res;
      int v;
      int ti;
      int li;
      int bi;
      int ri;
      if (cmd == CMD_LOAD) begin
        v = int'(value);
        if (load_row >= rows_used || load_col >= cols_used) restart_load();
        row_acc = (load_col == 0) ? v : row_acc + v;
        prefix[load_row*DIM_MAX + load_col] = row_acc + prefix_at(load_row - 1, load_col);
        if (load_col + 1 < cols_used) begin
          load_col++;
          table_done = 1'b0;
        end else if (load_row + 1 < rows_used) begin
          load_col = 0;
          load_row++;
          table_done = 1'b0;
        end else begin
          // last element: table complete, next load starts a new matrix
          load_col   = 0;
          load_row   = 0;
          table_done = 1'b1;
        end
        return;
      end
      ti = int'(t);
      li = int'(l);
      bi = int'(b);
      ri = int'(r);
      res.area_sum = '0;
      if (ti > bi || li > ri || bi >= rows_used || ri >= cols_used) begin
        res.status = STATUS_BAD_COORD;
      end else if (!table_done) begin
        res.status = STATUS_NOT_READY;
      end else begin
        res.status   = STATUS_OK;
        res.area_sum = AREA_W'(prefix_at(bi, ri) - prefix_at(ti - 1, ri)
                               - prefix_at(bi, li - 1) + prefix_at(ti - 1, li - 1));
      end
      awaited.push_back(res);
    endfunction

    function void check_item(logic signed [AREA_W-1:0] area_sum, status_t status);
      region_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $error("result with nothing awaited: region_sum %0d status %0d", area_sum, status);
        return;
      end
      want = awaited.pop_front();
      if (area_sum !== want.area_sum) begin
        errors++;
        $error("region_sum: expected %0d, got %0d", want.area_sum, area_sum);
      end
      if (status !== want.status) begin
        errors++;
        $error("status: expected %0d, got %0d", want.status, status);
      end
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// testbench top for summed_area_table_region_sum_unit: directed and random loads,
// region queries and dimension writes, checked by region_sum_scoreboard
// depends on sarsu_pkg and sarsu_tb_pkg
module tb_top;
  import sarsu_pkg::*;
  import sarsu_tb_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int BURST_ITEMS  = 300;
  localparam int ELEM_MAX     = 32767;
  localparam int ELEM_MIN     = -32768;

  typedef enum int {FILL_MIXED, FILL_MAX, FILL_MIN} fill_t;

  logic                      clk        = 1'b0;
  logic                      rst        = 1'b1;
  logic                      in_valid   = 1'b0;
  logic                      command    = CMD_LOAD;
  logic signed [ELEM_W-1:0]  value      = '0;
  logic [COORD_W-1:0]        top_row    = '0;
  logic [COORD_W-1:0]        left_col   = '0;
  logic [COORD_W-1:0]        bottom_row = '0;
  logic [COORD_W-1:0]        right_col  = '0;
  logic                      out_ready  = 1'b0;
  logic                      psel       = 1'b0;
  logic                      penable    = 1'b0;
  logic                      pwrite     = 1'b0;
  logic [CFG_ADDR_BITS-1:0]  paddr      = '0;
  logic [CFG_DATA_BITS-1:0]  pwdata     = '0;
  logic                      in_ready;
  logic                      out_valid;
  logic signed [AREA_W-1:0]  region_sum;
  status_t                   status;
  logic [CFG_DATA_BITS-1:0]  prdata;
  logic                      pready;

  region_sum_scoreboard sb;
  int  items_sent   = 0;
  int  burst_from   = 32'h7fff_ffff;
  bit  burst        = 1'b0;
  int  stall_cycles = 0;

  summed_area_table_region_sum_unit dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .command    (command),
    .value      (value),
    .top_row    (top_row),
    .left_col   (left_col),
    .bottom_row (bottom_row),
    .right_col  (right_col),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .region_sum (region_sum),
    .status     (status),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= burst || ($urandom_range(99) >= 33);
  end

  // handshakes are sampled mid-cycle, where nothing is changing
  always @(negedge clk) begin
    if (!rst && in_valid && in_ready)
      sb.note_item(command, value, top_row, left_col, bottom_row, right_col);
    if (!rst && out_valid && out_ready)
      sb.check_item(region_sum, status);
  end

  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_item(input logic cmd, input int val, input int t, input int l,
                           input int b, input int r);
    burst = (items_sent >= burst_from) && (items_sent < burst_from + BURST_ITEMS);
    while (!burst && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    value      <= ELEM_W'(val);
    top_row    <= COORD_W'(t);
    left_col   <= COORD_W'(l);
    bottom_row <= COORD_W'(b);
    right_col  <= COORD_W'(r);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    items_sent++;
  endtask

  task automatic send_query(input bit well_formed);
    int b;
    int t;
    int r;
    int l;
    if (well_formed) begin
      b = $urandom_range(sb.rows_used - 1);
      t = $urandom_range(b);
      r = $urandom_range(sb.cols_used - 1);
      l = $urandom_range(r);
      send_item(CMD_QUERY, $urandom, t, l, b, r);
    end else begin
      send_item(CMD_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic load_elements(input int count, input fill_t fill);
    int v;
    for (int i = 0; i < count; i++) begin
      case (fill)
        FILL_MAX: v = ELEM_MAX;
        FILL_MIN: v = ELEM_MIN;
        default: begin
          case ($urandom_range(9))
            0: v = ELEM_MAX;
            1: v = ELEM_MIN;
            default: v = $urandom;
          endcase
        end
      endcase
      // queries mixed into a load; well-formed ones after its first element find the table incomplete
      if (fill == FILL_MIXED && $urandom_range(11) == 0) send_query($urandom_range(1) == 1);
      send_item(CMD_LOAD, v, $urandom, $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    // a load in flight produces no result, so give it time to land
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_dim(input logic idx, input logic [CFG_DIM_BITS-1:0] dim);
    logic [CFG_DATA_BITS-1:0] data;
    data = $urandom;
    data[CFG_DIM_BITS-1:0] = dim;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    sb.write_reg(idx, data);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_dims(input logic [CFG_DIM_BITS-1:0] rows_raw,
                          input logic [CFG_DIM_BITS-1:0] cols_raw);
    wait_drained();
    write_dim(REG_NUM_ROWS, rows_raw);
    write_dim(REG_NUM_COLS, cols_raw);
  endtask

  initial begin
    int total;
    int split;
    int random_base;
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset dimensions, nothing loaded yet
    send_item(CMD_QUERY, 0, 0, 0, 63, 63);
    send_item(CMD_QUERY, 0, 5, 0, 4, 63);
    send_item(CMD_QUERY, 0, 0, 63, 63, 0);
    send_item(CMD_LOAD, ELEM_MAX, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0);

    // zero dimensions act as a single element
    set_dims(7'd0, 7'd0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD, ELEM_MIN, 63, 63, 63, 63);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD, ELEM_MAX, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 1, 0);
    send_item(CMD_QUERY, 0, 0, 0, 0, 1);
    send_item(CMD_QUERY, ELEM_MIN, 63, 63, 63, 63);

    set_dims(7'd2, 7'd3);
    send_item(CMD_LOAD, ELEM_MAX, 0, 0, 0, 0);
    send_item(CMD_LOAD, ELEM_MIN, 0, 0, 0, 0);
    send_item(CMD_LOAD, 1, 0, 0, 0, 0);
    send_item(CMD_LOAD, -1, 0, 0, 0, 0);
    send_item(CMD_LOAD, 0, 0, 0, 0, 0);
    send_item(CMD_LOAD, 16'h5555, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 1, 2);
    send_item(CMD_QUERY, 0, 1, 1, 1, 2);
    send_item(CMD_QUERY, 0, 0, 2, 1, 2);
    // starting a new matrix drops the complete flag
    send_item(CMD_LOAD, 7, 0, 0, 0, 0);
    send_item(CMD_QUERY, 0, 0, 0, 1, 2);

    // oversized row register saturates to the table height, sums at the high extreme
    set_dims(7'd127, 7'd4);
    load_elements(sb.rows_used * sb.cols_used, FILL_MAX);
    send_item(CMD_QUERY, $urandom, 0, 0, 63, 3);
    send_item(CMD_QUERY, $urandom, 1, 1, 63, 3);
    send_item(CMD_QUERY, $urandom, 63, 3, 63, 3);
    send_item(CMD_QUERY, $urandom, 0, 0, 0, 0);
    send_item(CMD_QUERY, $urandom, 0, 0, 63, 4);
    repeat (4) send_query(1'b1);
    // oversized column register saturates to the table width, sums at the low extreme
    set_dims(7'd4, 7'd100);
    load_elements(sb.rows_used * sb.cols_used, FILL_MIN);
    send_item(CMD_QUERY, $urandom, 0, 0, 3, 63);
    send_item(CMD_QUERY, $urandom, 0, 63, 3, 63);
    repeat (4) send_query(1'b1);

    random_base = items_sent;
    burst_from  = items_sent + 500;
    while (items_sent - random_base < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: set_dims(($urandom_range(1) == 1) ? 7'd0 : 7'($urandom_range(65, 127)),
                    7'($urandom_range(0, 6)));
        1: set_dims(7'($urandom_range(9, 64)), 7'($urandom_range(1, 3)));
        2: set_dims(7'($urandom_range(1, 3)), 7'($urandom_range(9, 64)));
        default: set_dims(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)));
      endcase
      repeat ($urandom_range(1, 3)) begin
        total = sb.rows_used * sb.cols_used;
        split = ($urandom_range(3) == 0) ? $urandom_range(total - 1) : total;
        load_elements(split, FILL_MIXED);
        if (split < total) begin
          repeat (2) send_query($urandom_range(1) == 1);
          load_elements(total - split, FILL_MIXED);
        end
        repeat ($urandom_range(3, 10)) send_query($urandom_range(4) != 0);
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sarsu_pkg.sv
design/sarsu_cfg.sv
design/summed_area_table_region_sum_unit.sv
sim/sarsu_tb_pkg.sv
sim/tb_top.sv
